### rtl/core/sgb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sgb_pkg;

  localparam int unsigned RingRows   = 16;
  localparam int unsigned RingBits   = 4;
  localparam int unsigned SampleBits = 16;

  typedef enum logic [2:0] {
    RegWidth   = 3'd0,
    RegHeight  = 3'd1,
    RegRadius  = 3'd2,
    RegTapC    = 3'd3,
    RegTap1    = 3'd4,
    RegTap2    = 3'd5,
    RegTap3    = 3'd6,
    RegTap4    = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StVert,
    StHorz,
    StRound,
    StOut
  } state_e;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/core/sgb_line_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module sgb_line_ram #(
  parameter int unsigned Depth = 16384,
  parameter int unsigned DataBits = 16,
  parameter int unsigned AddrBits = 14
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [AddrBits-1:0] waddr_i,
  input  wire logic [DataBits-1:0] wdata_i,
  input  wire logic [AddrBits-1:0] raddr_i,
  output      logic [DataBits-1:0] rdata_o
);
  logic [DataBits-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

### rtl/core/separable_gaussian_blur_2d.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake           Payload
// in        input      in_valid/in_ready   operation, sample
// out       output     out_valid/out_ready blurred_value, last_of_slice
// cfg       input      APB psel/penable    paddr, pwdata -> prdata
//
// Sequencing: one transaction at a time. A sample is written to the line RAM
// on acceptance; the next cycle checks whether an output is due. A pass then
// steps through a read state and a vertical accumulate state per tap, one
// horizontal step per column, then round and hand-off before out_valid.
// Reset: control cleared asynchronously; the line RAM is not cleared, only
// rows already received in the current slice are read.
// Stalls: the result sits in the output register until taken; in_ready is low
// from acceptance until the pass it triggers is done. A held result does not
// block the next transaction, but the pass that one triggers waits for it.
module separable_gaussian_blur_2d #(
  parameter int unsigned MAX_WIDTH   = 1024,
  parameter int unsigned MAX_HEIGHT  = 1024,
  parameter int unsigned MAX_RADIUS  = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic               operation_i,
  input  wire logic signed [15:0] sample_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic signed [31:0] blurred_value_o,
  output      logic               last_of_slice_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output      logic [31:0]        prdata,
  output      logic               pready
);
  localparam int unsigned ColBits  = $clog2(MAX_WIDTH);
  localparam int unsigned RowBits  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned AddrBits = sgb_pkg::RingBits + ColBits;

  // configuration
  logic [10:0] width_q, height_q;
  logic [2:0]  radius_q;
  logic [15:0] tap_q [5];
  logic        cfg_wr;
  logic [10:0] dim_clamp;
  logic [10:0] wv, hv;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  function automatic logic [10:0] clampd(input logic [10:0] v, input int unsigned mx);
    logic [10:0] r;
    if (v == 11'd0) r = 11'd1;
    else if (32'(v) > mx) r = 11'(mx);
    else r = v;
    return r;
  endfunction

  assign wv = clampd(pwdata[10:0], MAX_WIDTH);
  assign hv = clampd(pwdata[10:0], MAX_HEIGHT);
  assign dim_clamp = 11'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= clampd(11'd1024, MAX_WIDTH);
      height_q <= clampd(11'd1024, MAX_HEIGHT);
      radius_q <= 3'd0;
      tap_q[0] <= 16'hffff;
      for (int i = 1; i < 5; i++) tap_q[i] <= 16'd0;
    end else if (cfg_wr) begin
      unique case (sgb_pkg::reg_idx_e'(paddr[4:2]))
        sgb_pkg::RegWidth:  width_q <= wv;
        sgb_pkg::RegHeight: height_q <= hv;
        sgb_pkg::RegRadius: radius_q <= (32'(pwdata[2:0]) > MAX_RADIUS) ?
                                        3'(MAX_RADIUS) : pwdata[2:0];
        sgb_pkg::RegTapC:   tap_q[0] <= pwdata[15:0];
        sgb_pkg::RegTap1:   tap_q[1] <= pwdata[15:0];
        sgb_pkg::RegTap2:   tap_q[2] <= pwdata[15:0];
        sgb_pkg::RegTap3:   tap_q[3] <= pwdata[15:0];
        sgb_pkg::RegTap4:   tap_q[4] <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    unique case (sgb_pkg::reg_idx_e'(paddr[4:2]))
      sgb_pkg::RegWidth:  prdata = {21'd0, width_q | dim_clamp};
      sgb_pkg::RegHeight: prdata = {21'd0, height_q};
      sgb_pkg::RegRadius: prdata = {29'd0, radius_q};
      sgb_pkg::RegTapC:   prdata = {16'd0, tap_q[0]};
      sgb_pkg::RegTap1:   prdata = {16'd0, tap_q[1]};
      sgb_pkg::RegTap2:   prdata = {16'd0, tap_q[2]};
      sgb_pkg::RegTap3:   prdata = {16'd0, tap_q[3]};
      sgb_pkg::RegTap4:   prdata = {16'd0, tap_q[4]};
      default: prdata = 32'd0;
    endcase
  end

  // positions
  logic [ColBits-1:0] in_col_q, out_col_q;
  logic [RowBits-1:0] in_row_q, out_row_q;
  logic [ColBits-1:0] in_col_d, out_col_d;
  logic [RowBits-1:0] in_row_d, out_row_d;

  sgb_pkg::state_e state_q, state_d;
  logic signed [3:0] dx_q, dy_q, dx_d, dy_d;
  logic signed [63:0] vacc_q, vacc_d, hacc_q, hacc_d;
  logic rd_ok_q, rd_ok_d;
  logic signed [31:0] res_q, res_d;
  logic last_q, last_d;
  logic out_v_q, out_v_d;
  // one emit check owed per accepted transaction
  logic try_q, try_d;

  // store write
  logic ram_we;
  logic [AddrBits-1:0] waddr, raddr;
  logic [15:0] rdata;
  logic [sgb_pkg::SampleBits-1:0] smp;
  logic signed [15:0] smp_ext;
  logic accept;
  logic [RowBits-1:0] wrow;
  logic [ColBits-1:0] wcol;

  assign accept = in_valid_i && in_ready_o;
  assign smp = sample_i[sgb_pkg::SampleBits-1:0];
  assign smp_ext = 16'($signed(smp));
  assign wrow = (32'(in_row_q) >= 32'(height_q)) ? '0 : in_row_q;
  assign wcol = (32'(in_col_q) >= 32'(width_q)) ? '0 : in_col_q;
  assign ram_we = accept && !operation_i;
  assign waddr = {wrow[sgb_pkg::RingBits-1:0], wcol};

  // current read coordinates
  logic signed [13:0] xs, ys;
  logic in_x, in_y;
  assign xs = 14'($signed({1'b0, out_col_q})) + 14'(dx_q);
  assign ys = 14'($signed({1'b0, out_row_q})) + 14'(dy_q);
  assign in_x = xs >= 0 && xs < $signed({3'b0, width_q});
  assign in_y = ys >= 0 && ys < $signed({3'b0, height_q});
  assign raddr = {ys[sgb_pkg::RingBits-1:0], xs[ColBits-1:0]};

  sgb_line_ram #(
    .Depth(sgb_pkg::RingRows * (1 << ColBits)),
    .DataBits(16),
    .AddrBits(AddrBits)
  ) u_ram (
    .clk_i(clk_i), .we_i(ram_we), .waddr_i(waddr), .wdata_i(smp_ext),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // readiness check
  logic [RowBits:0] need_r;
  logic [ColBits:0] need_c;
  logic ready_to_emit;
  always_comb begin
    need_r = (32'(out_row_q) + 32'(radius_q) > 32'(height_q) - 1) ?
             (RowBits+1)'(height_q - 11'd1) : (RowBits+1)'(out_row_q) + (RowBits+1)'(radius_q);
    need_c = (32'(out_col_q) + 32'(radius_q) > 32'(width_q) - 1) ?
             (ColBits+1)'(width_q - 11'd1) : (ColBits+1)'(out_col_q) + (ColBits+1)'(radius_q);
    ready_to_emit = (32'(out_row_q) < 32'(height_q)) && (32'(out_col_q) < 32'(width_q)) &&
      ((32'(need_r) < 32'(in_row_q)) ||
       (32'(need_r) == 32'(in_row_q) && 32'(need_c) < 32'(in_col_q)));
  end

  logic [2:0] ady, adx;
  assign ady = dy_q[3] ? 3'(-dy_q) : dy_q[2:0];
  assign adx = dx_q[3] ? 3'(-dx_q) : dx_q[2:0];
  logic signed [16:0] wy;
  assign wy = $signed({1'b0, tap_q[ady]});
  logic signed [32:0] prod_v;
  assign prod_v = wy * $signed(rdata);
  logic signed [31:0] vsat;
  assign vsat = sgb_pkg::sat32(vacc_q);
  logic signed [48:0] prod_h;
  assign prod_h = $signed({1'b0, tap_q[adx]}) * vsat;
  logic signed [63:0] rounded;
  assign rounded = (hacc_q + 64'sd32768) >>> 16;
  logic signed [3:0] rad_s;
  assign rad_s = $signed({1'b0, radius_q});
  logic is_last;
  assign is_last = 32'(out_col_q) == 32'(width_q) - 1 && 32'(out_row_q) == 32'(height_q) - 1;

  assign in_ready_o = state_q == sgb_pkg::StIdle && !try_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sgb_pkg::StIdle:  if (try_q && ready_to_emit && !out_v_q) state_d = sgb_pkg::StRead;
      sgb_pkg::StRead:  state_d = sgb_pkg::StVert;
      sgb_pkg::StVert:  if (dy_q == rad_s) state_d = sgb_pkg::StHorz;
                        else state_d = sgb_pkg::StRead;
      sgb_pkg::StHorz:  if (dx_q == rad_s) state_d = sgb_pkg::StRound;
                        else state_d = sgb_pkg::StRead;
      sgb_pkg::StRound: state_d = sgb_pkg::StOut;
      sgb_pkg::StOut:   state_d = sgb_pkg::StIdle;
      default:          state_d = sgb_pkg::StIdle;
    endcase
  end

  // datapath
  always_comb begin
    dx_d = dx_q; dy_d = dy_q; vacc_d = vacc_q; hacc_d = hacc_q;
    rd_ok_d = rd_ok_q; res_d = res_q; last_d = last_q; out_v_d = out_v_q;
    try_d = try_q;
    in_col_d = in_col_q; in_row_d = in_row_q;
    out_col_d = out_col_q; out_row_d = out_row_q;
    if (out_v_q && out_ready_i) out_v_d = 1'b0;
    if (accept) try_d = 1'b1;
    if (accept && !operation_i) begin
      in_row_d = wrow;
      if (32'(in_row_q) >= 32'(height_q)) begin
        out_col_d = '0; out_row_d = '0;
      end
      if (32'(wcol) + 1 >= 32'(width_q)) begin
        in_col_d = '0; in_row_d = wrow + RowBits'(1);
      end else begin
        in_col_d = wcol + ColBits'(1);
      end
    end
    unique case (state_q)
      sgb_pkg::StIdle: begin
        dx_d = -rad_s; dy_d = -rad_s; vacc_d = '0; hacc_d = '0;
        // drop the check when nothing is due, else hold it until the output is free
        if (try_q && (!ready_to_emit || !out_v_q)) try_d = 1'b0;
      end
      sgb_pkg::StRead: rd_ok_d = in_x && in_y;
      sgb_pkg::StVert: begin
        if (rd_ok_q) vacc_d = vacc_q + 64'(prod_v);
        if (dy_q != rad_s) dy_d = dy_q + 4'sd1;
      end
      sgb_pkg::StHorz: begin
        if (in_x)
          hacc_d = hacc_q + 64'(prod_h);
        vacc_d = '0; dy_d = -rad_s; dx_d = dx_q + 4'sd1;
      end
      sgb_pkg::StRound: begin
        res_d = sgb_pkg::sat32(rounded);
        last_d = is_last;
      end
      sgb_pkg::StOut: begin
        out_v_d = 1'b1;
        if (is_last) begin
          in_col_d = '0; in_row_d = '0; out_col_d = '0; out_row_d = '0;
        end else if (32'(out_col_q) + 1 >= 32'(width_q)) begin
          out_col_d = '0; out_row_d = out_row_q + RowBits'(1);
        end else begin
          out_col_d = out_col_q + ColBits'(1);
        end
      end
      default: ;
    endcase
    if (cfg_wr) begin
      in_col_d = '0; in_row_d = '0; out_col_d = '0; out_row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sgb_pkg::StIdle;
      out_v_q <= 1'b0;
      try_q <= 1'b0;
      in_col_q <= '0; in_row_q <= '0; out_col_q <= '0; out_row_q <= '0;
      dx_q <= '0; dy_q <= '0; rd_ok_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_v_q <= out_v_d;
      try_q <= try_d;
      in_col_q <= in_col_d; in_row_q <= in_row_d;
      out_col_q <= out_col_d; out_row_q <= out_row_d;
      dx_q <= dx_d; dy_q <= dy_d; rd_ok_q <= rd_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vacc_q <= vacc_d; hacc_q <= hacc_d; res_q <= res_d; last_q <= last_d;
  end

  assign out_valid_o = out_v_q;
  assign blurred_value_o = res_q;
  assign last_of_slice_o = last_q;
endmodule
`default_nettype wire

### tb/sgb_checker.sv
`timescale 1ns / 1ps
package tb_sgb_pkg;
  typedef enum logic {
    OpSample = 1'b0,
    OpFlush  = 1'b1
  } blur_op_e;
endpackage

module sgb_checker (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_ready_i,
  input  wire logic               operation_i,
  input  wire logic signed [15:0] sample_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_ready_i,
  input  wire logic signed [31:0] blurred_value_i,
  input  wire logic               last_of_slice_i,
  input  wire logic               psel_i,
  input  wire logic               penable_i,
  input  wire logic               pwrite_i,
  input  wire logic               pready_i,
  input  wire logic [4:0]         paddr_i,
  input  wire logic [31:0]        pwdata_i,
  output int                      fail_count_o,
  output int                      pending_o,
  output int                      pixels_seen_o
);

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } blurred_px_t;

  localparam int unsigned LineW = 1024;

  blurred_px_t        expected_px_q[$];
  logic signed [15:0] line_mem [sgb_pkg::RingRows * LineW];
  int                 width_cfg, height_cfg, radius_cfg;
  logic [15:0]        taps [5];
  int                 in_col, in_row, out_col, out_row;

  assign pending_o = expected_px_q.size();

  task automatic report_mismatch(string what, longint exp_v, longint got_v);
    $display("%0t mismatch %s: expected %0d got %0d", $realtime, what, exp_v, got_v);
    fail_count_o++;
  endtask

  function automatic longint tap_weight(int d);
    return (d < 0) ? longint'(taps[-d]) : longint'(taps[d]);
  endfunction

  function automatic int clamp_dim(logic [10:0] v);
    if (v == 0) return 1;
    if (v > 11'd1024) return 1024;
    return int'(v);
  endfunction

  function automatic longint sat_q(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic restart_slice();
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
  endtask

  // Emits the next raster pixel once its lowest-right neighbor has arrived.
  task automatic try_blur();
    int          need_r, need_c, x, y;
    longint      acc, col_sum;
    blurred_px_t px;
    if (out_row >= height_cfg || out_col >= width_cfg) return;
    need_r = (out_row + radius_cfg > height_cfg - 1) ? height_cfg - 1 : out_row + radius_cfg;
    need_c = (out_col + radius_cfg > width_cfg - 1) ? width_cfg - 1 : out_col + radius_cfg;
    if (!(need_r < in_row || (need_r == in_row && need_c < in_col))) return;
    acc = 0;
    for (int dx = -radius_cfg; dx <= radius_cfg; dx++) begin
      x = out_col + dx;
      if (x < 0 || x >= width_cfg) continue;
      col_sum = 0;
      for (int dy = -radius_cfg; dy <= radius_cfg; dy++) begin
        y = out_row + dy;
        if (y < 0 || y >= height_cfg) continue;
        col_sum += tap_weight(dy) *
                   longint'(line_mem[(y % sgb_pkg::RingRows) * LineW + x]);
      end
      acc += tap_weight(dx) * sat_q(col_sum);
    end
    // round half up into Q.16, then clip
    px.value = 32'(sat_q((acc + 32768) >>> 16));
    px.last  = (out_col == width_cfg - 1) && (out_row == height_cfg - 1);
    expected_px_q.push_back(px);
    if (px.last) restart_slice();
    else begin
      out_col++;
      if (out_col >= width_cfg) begin
        out_col = 0;
        out_row++;
      end
    end
  endtask

  task automatic take_item(tb_sgb_pkg::blur_op_e op, logic signed [15:0] s);
    if (op == tb_sgb_pkg::OpSample) begin
      if (in_row >= height_cfg) restart_slice();  // new slice drops the drain
      if (in_col >= width_cfg) in_col = 0;
      line_mem[(in_row % sgb_pkg::RingRows) * LineW + in_col] = s;
      in_col++;
      if (in_col >= width_cfg) begin
        in_col = 0;
        in_row++;
      end
    end
    try_blur();
  endtask

  task automatic apply_cfg(logic [2:0] idx, logic [31:0] d);
    case (sgb_pkg::reg_idx_e'(idx))
      sgb_pkg::RegWidth:  width_cfg = clamp_dim(d[10:0]);
      sgb_pkg::RegHeight: height_cfg = clamp_dim(d[10:0]);
      sgb_pkg::RegRadius: radius_cfg = (d[2:0] > 3'd4) ? 4 : int'(d[2:0]);
      sgb_pkg::RegTapC:   taps[0] = d[15:0];
      sgb_pkg::RegTap1:   taps[1] = d[15:0];
      sgb_pkg::RegTap2:   taps[2] = d[15:0];
      sgb_pkg::RegTap3:   taps[3] = d[15:0];
      sgb_pkg::RegTap4:   taps[4] = d[15:0];
      default: ;
    endcase
    restart_slice();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    blurred_px_t px;
    if (!rst_ni) begin
      expected_px_q.delete();
      restart_slice();
      width_cfg = 1024; height_cfg = 1024; radius_cfg = 0;
      taps[0] = 16'hffff;
      for (int i = 1; i < 5; i++) taps[i] = '0;
      fail_count_o = 0;
      pixels_seen_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        pixels_seen_o++;
        if (expected_px_q.size() == 0) begin
          report_mismatch("unexpected pixel", 0, blurred_value_i);
        end else begin
          px = expected_px_q.pop_front();
          if (blurred_value_i !== px.value)
            report_mismatch("blurred_value", px.value, blurred_value_i);
          if (last_of_slice_i !== px.last)
            report_mismatch("last_of_slice", px.last, last_of_slice_i);
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i) apply_cfg(paddr_i[4:2], pwdata_i);
      if (in_valid_i && in_ready_i)
        take_item(tb_sgb_pkg::blur_op_e'(operation_i), sample_i);
    end
  end

endmodule

### tb/tb_separable_gaussian_blur_2d.sv
`timescale 1ns / 1ps
module tb_separable_gaussian_blur_2d;

  localparam int TargetItems = 1600;
  // settle time after the last expected pixel: one full 9x9 kernel pass and margin
  localparam int SettleCycles = 200;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               operation = tb_sgb_pkg::OpSample;
  logic signed [15:0] sample = '0;
  logic               out_ready = 1'b0;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  wire                in_ready, out_valid, last_of_slice, pready;
  wire signed [31:0]  blurred_value;
  wire [31:0]         prdata;
  int                 fail_count, pending, pixels_seen;
  int                 items_sent = 0, cfg_writes = 0, slices_started = 0;
  bit                 quiet = 1'b0;  // phase without any idling on either side

  separable_gaussian_blur_2d i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .operation_i(operation), .sample_i(sample),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .blurred_value_o(blurred_value), .last_of_slice_o(last_of_slice),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  sgb_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .operation_i(operation), .sample_i(sample),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .blurred_value_i(blurred_value), .last_of_slice_i(last_of_slice),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr), .pwdata_i(pwdata),
    .fail_count_o(fail_count), .pending_o(pending), .pixels_seen_o(pixels_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  // Output side: random backpressure per transaction; ready stays up when no stall.
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // One input transaction; valid is only dropped when a gap precedes the next one.
  task automatic send_item(tb_sgb_pkg::blur_op_e op, logic signed [15:0] s);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    sample    <= s;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Wait for all predicted pixels, then let the block finish any pass that yields nothing.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // APB write: setup then access; junk in upper bits must be ignored.
  task automatic cfg_write(sgb_pkg::reg_idx_e idx, logic [31:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    cfg_writes++;
  endtask

  task automatic configure(logic [31:0] w, logic [31:0] h, logic [31:0] r,
                           logic [15:0] tc, logic [15:0] t1, logic [15:0] t2,
                           logic [15:0] t3, logic [15:0] t4);
    settle();
    cfg_write(sgb_pkg::RegTapC, tc);
    cfg_write(sgb_pkg::RegTap1, t1);
    cfg_write(sgb_pkg::RegTap2, t2);
    cfg_write(sgb_pkg::RegTap3, t3);
    cfg_write(sgb_pkg::RegTap4, t4);
    cfg_write(sgb_pkg::RegRadius, r);
    cfg_write(sgb_pkg::RegHeight, h);
    cfg_write(sgb_pkg::RegWidth, w);
  endtask

  function automatic logic [15:0] rand_tap();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 16'h0000;
    if (pick == 1) return 16'hffff;
    return 16'($urandom);
  endfunction

  function automatic logic signed [15:0] rand_sample();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 16'sh7fff;
    if (pick == 1) return 16'sh8000;
    return 16'($urandom);
  endfunction

  initial begin
    int w, h, r, n_px, drain, budget;
    logic [31:0] w_raw, h_raw, r_raw;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed ---
    // reset config: 1024 wide, radius 0, unit center tap -> pixel out per sample
    send_item(tb_sgb_pkg::OpFlush, 16'sh1234);  // nothing ready yet
    send_item(tb_sgb_pkg::OpSample, 16'sh7fff);
    send_item(tb_sgb_pkg::OpSample, 16'sh8000);
    send_item(tb_sgb_pkg::OpSample, 16'sh0000);
    send_item(tb_sgb_pkg::OpSample, -16'sd1);
    // 0x0 dims clamp to 1x1, radius 7 clamps to 4, all taps full scale
    configure(32'h0, 32'h0, 32'h7, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_item(tb_sgb_pkg::OpSample, 16'sh7fff);
    send_item(tb_sgb_pkg::OpSample, 16'sh8000);
    // 3x2, radius 4, full taps: vertical and horizontal saturation
    configure(32'h3, 32'h2, 32'h4, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    repeat (6) send_item(tb_sgb_pkg::OpSample, 16'sh7fff);
    repeat (4) send_item(tb_sgb_pkg::OpFlush, '0);
    repeat (6) send_item(tb_sgb_pkg::OpSample, 16'sh8000);
    repeat (4) send_item(tb_sgb_pkg::OpFlush, '0);
    // 4x3, radius 2, zero taps; new slice started while the old one drains
    configure(32'hfffff004, 32'h3, 32'h2, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
    repeat (12) send_item(tb_sgb_pkg::OpSample, rand_sample());
    send_item(tb_sgb_pkg::OpFlush, '0);
    repeat (3) send_item(tb_sgb_pkg::OpSample, rand_sample());

    // --- random phases ---
    while (items_sent < TargetItems) begin
      quiet = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0: w = $urandom_range(11, 40);
        1: w = 1;
        default: w = $urandom_range(2, 10);
      endcase
      h = (w > 10) ? $urandom_range(1, 6) : $urandom_range(1, 12);
      r = $urandom_range(0, 4);
      w_raw = {21'($urandom), 11'(w)};
      h_raw = {21'($urandom), 11'(h)};
      r_raw = {29'($urandom), 3'(r)};
      case ($urandom_range(0, 19))
        0: begin w_raw = 32'h7ff; w = 1024; h = 2; h_raw = 32'h2; end
        1: begin h_raw = 32'h7ff; h = 1024; end  // slice never ends, cut by next write
        2: begin r_raw = 32'h6; r = 4; end
        default: ;
      endcase
      configure(w_raw, h_raw, r_raw, rand_tap(), rand_tap(), rand_tap(), rand_tap(),
                rand_tap());
      budget = 300;
      for (int sl = 0; sl < $urandom_range(1, 3) && budget > 0; sl++) begin
        n_px = (h == 1024) ? w * 12 : w * h;
        if ($urandom_range(0, 9) == 0) n_px = $urandom_range(1, n_px);  // broken slice
        slices_started++;
        for (int i = 0; i < n_px && budget > 0 && items_sent < TargetItems; i++) begin
          if ($urandom_range(0, 19) == 0) send_item(tb_sgb_pkg::OpFlush, rand_sample());
          send_item(tb_sgb_pkg::OpSample, rand_sample());
          budget--;
        end
        // mostly a full drain; sometimes short so the next slice cuts it off
        drain = (w < 16) ? w * r + r + 2 : r + 2;
        if ($urandom_range(0, 4) == 0) drain = $urandom_range(0, 2);
        repeat (drain) send_item(tb_sgb_pkg::OpFlush, rand_sample());
      end
    end

    settle();
    $display("Ran %0d input transactions, %0d blurred pixels, %0d register writes,",
             items_sent, pixels_seen, cfg_writes);
    $display("over %0d random slices with radius 0..4 and clamped dimensions.",
             slices_started);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
